// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL files that include them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define WMHSM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("wmhsm assertion failed");
// Check that a condition holds in the cycle after a trigger.
`define WMHSM_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("wmhsm assertion failed");
`else
`define WMHSM_ASSERT(lbl, clk, rst_n, prop)
`define WMHSM_ASSERT_NEXT(lbl, clk, rst_n, trig, cons)
`endif
`endif

// ===== design/wmhsm_pkg.sv =====
package wmhsm_pkg;

  localparam int NUM_RANGES = 4;
  localparam int MAX_RADIUS = 255;
  localparam int MAX_DIM    = 4096;

  localparam int COORD_W = 12;
  localparam int CHAN_W  = 8;
  localparam int DIM_W   = 13;
  localparam int RAD_W   = 8;
  localparam int SUM_W   = 27;
  localparam int CNT_W   = 18;
  localparam int RANGE_W = 49;
  localparam int PROD_W  = CHAN_W + CNT_W;
  localparam int CFG_IDX_W = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 4'd0,
    CFG_RADIUS  = 4'd1,
    CFG_COLS    = 4'd2,
    CFG_ROWS    = 4'd3,
    CFG_RANGE_0 = 4'd4,
    CFG_RANGE_1 = 4'd5,
    CFG_RANGE_2 = 4'd6,
    CFG_RANGE_3 = 4'd7
  } cfg_idx_t;

  localparam logic             RST_ENABLE = 1'b1;
  localparam logic [RAD_W-1:0] RST_RADIUS = 8'd10;
  localparam logic [DIM_W-1:0] RST_COLS   = 13'd640;
  localparam logic [DIM_W-1:0] RST_ROWS   = 13'd480;

  localparam logic [RANGE_W-1:0] RST_RANGE [4] = '{
    49'd281562219910911,
    49'd292557336516351,
    49'd298054559438556,
    49'd281520444302591
  };

  typedef struct packed {
    logic [COORD_W-1:0] centre_x;
    logic [COORD_W-1:0] centre_y;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  hue;
    logic [CHAN_W-1:0]  saturation;
    logic [CHAN_W-1:0]  brightness;
    logic               frame_last;
  } wmhsm_in_t;

  typedef struct packed {
    logic is_skin;
    logic score_code;
  } wmhsm_out_t;

endpackage

// ===== design/window_mean_hsv_skin_match.sv =====
// HSV skin test over a square window. Pixels enter one per clock on start
// (busy stays low); the centre is taken from the first pixel of each frame and
// the window sums H, S, V and a count of in-window pixels. A pixel marked
// frame_last gives one result beat on out_strobe, through the input register,
// the snapshot register and the result register; other pixels give none. The
// receiver cannot stall: out_data is valid only in the single strobe cycle.
// Throughput is one pixel per cycle, set by the accumulator loop; the range
// compare sits between the snapshot and result registers. Configuration
// writes are always ready and must be made while no frame is in flight.
`include "assert_macros.svh"

module window_mean_hsv_skin_match (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  wmhsm_pkg::wmhsm_in_t                  in_data,
  output logic                                  out_strobe,
  output wmhsm_pkg::wmhsm_out_t                 out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wmhsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wmhsm_pkg::RANGE_W-1:0]         cfg_data
);
  import wmhsm_pkg::*;

  // Configuration registers
  logic               enable_r;
  logic [RAD_W-1:0]   radius_r;
  logic [DIM_W-1:0]   cols_r;
  logic [DIM_W-1:0]   rows_r;
  logic [RANGE_W-1:0] range_r [NUM_RANGES];

  // Input register
  logic      s1_valid_r;
  wmhsm_in_t s1_data_r;

  // Frame accumulation state
  logic [SUM_W-1:0]   hsum_r, ssum_r, vsum_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [COORD_W-1:0] lc_x_r, lc_y_r;
  logic               started_r;

  // Snapshot taken on the last pixel
  logic               ev_valid_r, ev_ok_r;
  logic [SUM_W-1:0]   ev_hsum_r, ev_ssum_r, ev_vsum_r;
  logic [CNT_W-1:0]   ev_cnt_r;

  // Result register
  logic       out_strobe_r;
  wmhsm_out_t out_data_r;

  // Stage two combinational signals
  logic [COORD_W-1:0]      cx, cy;
  logic [RAD_W-1:0]        rad;
  logic [DIM_W-1:0]        cols_c, rows_c;
  logic signed [DIM_W+1:0] x_lo, x_hi, y_lo, y_hi, x_lim, y_lim, x_end, y_end;
  logic signed [DIM_W+1:0] px_s, py_s;
  logic                    in_win, centre_ok, add_px;
  logic [SUM_W-1:0]        hsum_nxt, ssum_nxt, vsum_nxt;
  logic [CNT_W-1:0]        cnt_nxt;
  logic                    eval_ok_nxt;
  logic                    skin_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown indexes drop the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= RST_ENABLE;
      radius_r <= RST_RADIUS;
      cols_r   <= RST_COLS;
      rows_r   <= RST_ROWS;
      for (int k = 0; k < NUM_RANGES; k++) begin
        range_r[k] <= RST_RANGE[k];
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE: enable_r <= cfg_data[0];
        CFG_RADIUS: radius_r <= cfg_data[RAD_W-1:0];
        CFG_COLS:   cols_r   <= cfg_data[DIM_W-1:0];
        CFG_ROWS:   rows_r   <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
      for (int k = 0; k < NUM_RANGES; k++) begin
        if (cfg_index == CFG_RANGE_0 + CFG_IDX_W'(k)) begin
          range_r[k] <= cfg_data;
        end
      end
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start;
    end
    if (start) begin
      s1_data_r <= in_data;
    end
  end

  // Window bounds, clipped to the frame
  always_comb begin
    cx     = started_r ? lc_x_r : s1_data_r.centre_x;
    cy     = started_r ? lc_y_r : s1_data_r.centre_y;
    rad    = (32'(radius_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_r;
    cols_c = (32'(cols_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : cols_r;
    rows_c = (32'(rows_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : rows_r;

    x_lo  = (cx >= COORD_W'(rad)) ? signed'((DIM_W+2)'(cx - COORD_W'(rad))) : '0;
    y_lo  = (cy >= COORD_W'(rad)) ? signed'((DIM_W+2)'(cy - COORD_W'(rad))) : '0;
    x_end = signed'((DIM_W+2)'(cx) + (DIM_W+2)'(rad));
    y_end = signed'((DIM_W+2)'(cy) + (DIM_W+2)'(rad));
    x_lim = signed'((DIM_W+2)'(cols_c)) - signed'((DIM_W+2)'(1));
    y_lim = signed'((DIM_W+2)'(rows_c)) - signed'((DIM_W+2)'(1));
    x_hi  = (x_end > x_lim) ? x_lim : x_end;
    y_hi  = (y_end > y_lim) ? y_lim : y_end;

    px_s = signed'((DIM_W+2)'(s1_data_r.pixel_x));
    py_s = signed'((DIM_W+2)'(s1_data_r.pixel_y));
    in_win = (px_s >= x_lo) && (px_s <= x_hi) && (py_s >= y_lo) && (py_s <= y_hi);
    add_px = in_win && (cnt_r < COUNT_MAX);
    centre_ok = (DIM_W'(cx) < cols_c) && (DIM_W'(cy) < rows_c);

    hsum_nxt = hsum_r;
    ssum_nxt = ssum_r;
    vsum_nxt = vsum_r;
    cnt_nxt  = cnt_r;
    if (add_px) begin
      hsum_nxt = hsum_r + SUM_W'(s1_data_r.hue);
      ssum_nxt = ssum_r + SUM_W'(s1_data_r.saturation);
      vsum_nxt = vsum_r + SUM_W'(s1_data_r.brightness);
      cnt_nxt  = cnt_r + CNT_W'(1);
    end
    eval_ok_nxt = enable_r && centre_ok && (x_hi > x_lo) && (y_hi > y_lo) && (cnt_nxt != '0);
  end

  // Accumulate, latch the centre and snapshot on the last pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsum_r     <= '0;
      ssum_r     <= '0;
      vsum_r     <= '0;
      cnt_r      <= '0;
      lc_x_r     <= '0;
      lc_y_r     <= '0;
      started_r  <= 1'b0;
      ev_valid_r <= 1'b0;
    end else begin
      ev_valid_r <= s1_valid_r && s1_data_r.frame_last;
      if (s1_valid_r) begin
        if (!started_r) begin
          lc_x_r <= s1_data_r.centre_x;
          lc_y_r <= s1_data_r.centre_y;
        end
        if (s1_data_r.frame_last) begin
          hsum_r    <= '0;
          ssum_r    <= '0;
          vsum_r    <= '0;
          cnt_r     <= '0;
          started_r <= 1'b0;
        end else begin
          hsum_r    <= hsum_nxt;
          ssum_r    <= ssum_nxt;
          vsum_r    <= vsum_nxt;
          cnt_r     <= cnt_nxt;
          started_r <= 1'b1;
        end
      end
    end
    if (s1_valid_r && s1_data_r.frame_last) begin
      ev_hsum_r <= hsum_nxt;
      ev_ssum_r <= ssum_nxt;
      ev_vsum_r <= vsum_nxt;
      ev_cnt_r  <= cnt_nxt;
      ev_ok_r   <= eval_ok_nxt;
    end
  end

  // Test min*count <= sum <= max*count per channel for each valid range
  always_comb begin
    logic [RANGE_W-1:0] w;
    logic [SUM_W-1:0]   p_hmin, p_smin, p_vmin, p_hmax, p_smax, p_vmax;
    logic               hit;
    skin_nxt = 1'b0;
    for (int k = 0; k < NUM_RANGES; k++) begin
      w      = range_r[k];
      p_hmin = SUM_W'(PROD_W'(w[47:40]) * PROD_W'(ev_cnt_r));
      p_smin = SUM_W'(PROD_W'(w[39:32]) * PROD_W'(ev_cnt_r));
      p_vmin = SUM_W'(PROD_W'(w[31:24]) * PROD_W'(ev_cnt_r));
      p_hmax = SUM_W'(PROD_W'(w[23:16]) * PROD_W'(ev_cnt_r));
      p_smax = SUM_W'(PROD_W'(w[15:8])  * PROD_W'(ev_cnt_r));
      p_vmax = SUM_W'(PROD_W'(w[7:0])   * PROD_W'(ev_cnt_r));
      hit = w[48] &&
            (ev_hsum_r >= p_hmin) && (ev_hsum_r <= p_hmax) &&
            (ev_ssum_r >= p_smin) && (ev_ssum_r <= p_smax) &&
            (ev_vsum_r >= p_vmin) && (ev_vsum_r <= p_vmax);
      skin_nxt = skin_nxt | hit;
    end
    skin_nxt = skin_nxt && ev_ok_r;
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ev_valid_r;
    end
    if (ev_valid_r) begin
      out_data_r.is_skin    <= skin_nxt;
      out_data_r.score_code <= skin_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // A last pixel in the input register yields a result beat via the snapshot and result registers
  `WMHSM_ASSERT(a_last_gives_result, clk, rst_n, (s1_valid_r && s1_data_r.frame_last) |-> ##2 out_strobe)
  // No result beat without an earlier last pixel in the input register
  `WMHSM_ASSERT(a_no_spurious_result, clk, rst_n, out_strobe |-> $past(s1_valid_r && s1_data_r.frame_last, 2))
  // A failed precondition never reports skin
  `WMHSM_ASSERT_NEXT(a_gate_blocks_skin, clk, rst_n, ev_valid_r && !ev_ok_r, !out_data.is_skin)
  // Sums and frame state clear after a last pixel
  `WMHSM_ASSERT_NEXT(a_clear_after_last, clk, rst_n, s1_valid_r && s1_data_r.frame_last, cnt_r == '0 && !started_r)

endmodule

// ===== tb/sv/window_mean_hsv_skin_match_tb.sv =====
module window_mean_hsv_skin_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wmhsm_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PIXELS = 1450;
  localparam int MAX_REPORTS   = 10;
  localparam int RANGE_SEL_W   = $clog2(NUM_RANGES);

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd12;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  wmhsm_in_t            in_data;
  logic                 out_strobe;
  wmhsm_out_t           out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RANGE_W-1:0]   cfg_data;

  // Shadow copy of the register file
  logic               en_q;
  logic [RAD_W-1:0]   radius_q;
  logic [DIM_W-1:0]   cols_q;
  logic [DIM_W-1:0]   rows_q;
  logic [RANGE_W-1:0] range_q [NUM_RANGES];

  // Mirror of the window accumulators
  logic [SUM_W-1:0]   hue_acc;
  logic [SUM_W-1:0]   sat_acc;
  logic [SUM_W-1:0]   val_acc;
  logic [CNT_W-1:0]   px_count;
  logic [COORD_W-1:0] centre_col;
  logic [COORD_W-1:0] centre_row;
  logic               frame_open;

  wmhsm_out_t skin_verdicts [$];
  wmhsm_out_t due_verdict;
  int         mismatches  = 0;
  int         idle_cycles = 0;
  int         burst_left  = 0;
  bit         gaps_on     = 1'b1;

  window_mean_hsv_skin_match uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mean test in integers: min*count <= sum <= max*count on every channel
  function automatic bit range_hit(input logic [RANGE_W-1:0] w);
    longint n;
    n = longint'(px_count);
    if (!w[48]) return 1'b0;
    return (longint'(hue_acc) >= longint'(w[47:40]) * n) &&
           (longint'(hue_acc) <= longint'(w[23:16]) * n) &&
           (longint'(sat_acc) >= longint'(w[39:32]) * n) &&
           (longint'(sat_acc) <= longint'(w[15:8]) * n) &&
           (longint'(val_acc) >= longint'(w[31:24]) * n) &&
           (longint'(val_acc) <= longint'(w[7:0]) * n);
  endfunction

  // Advance the window sums by one pixel; on a last pixel queue the verdict
  task automatic accumulate_pixel(input wmhsm_in_t px);
    int cx, cy, r, cols, rows, xlo, xhi, ylo, yhi, pxi, pyi;
    bit skin;
    if (!frame_open) begin
      centre_col = px.centre_x;
      centre_row = px.centre_y;
      frame_open = 1'b1;
    end
    cx   = int'(centre_col);
    cy   = int'(centre_row);
    r    = int'(radius_q);
    cols = (int'(cols_q) > MAX_DIM) ? MAX_DIM : int'(cols_q);
    rows = (int'(rows_q) > MAX_DIM) ? MAX_DIM : int'(rows_q);
    xlo  = (cx - r < 0) ? 0 : cx - r;
    ylo  = (cy - r < 0) ? 0 : cy - r;
    xhi  = (cx + r > cols - 1) ? cols - 1 : cx + r;
    yhi  = (cy + r > rows - 1) ? rows - 1 : cy + r;
    pxi  = int'(px.pixel_x);
    pyi  = int'(px.pixel_y);
    // Sum only in-window pixels, and stop once the count is full
    if (pxi >= xlo && pxi <= xhi && pyi >= ylo && pyi <= yhi && px_count < COUNT_MAX) begin
      hue_acc += SUM_W'(px.hue);
      sat_acc += SUM_W'(px.saturation);
      val_acc += SUM_W'(px.brightness);
      px_count++;
    end
    if (px.frame_last) begin
      skin = 1'b0;
      if (en_q && cx < cols && cy < rows && xhi > xlo && yhi > ylo && px_count != '0) begin
        for (int k = 0; k < NUM_RANGES; k++) begin
          if (range_hit(range_q[k])) skin = 1'b1;
        end
      end
      skin_verdicts.push_back('{is_skin: skin, score_code: skin});
      hue_acc    = '0;
      sat_acc    = '0;
      val_acc    = '0;
      px_count   = '0;
      frame_open = 1'b0;
    end
  endtask

  function automatic wmhsm_in_t pix(input int cx, input int cy, input int px, input int py,
                                    input int h, input int s, input int v, input logic last);
    return '{centre_x: COORD_W'(cx), centre_y: COORD_W'(cy),
             pixel_x: COORD_W'(px), pixel_y: COORD_W'(py),
             hue: CHAN_W'(h), saturation: CHAN_W'(s), brightness: CHAN_W'(v),
             frame_last: last};
  endfunction

  // Nudge a channel around its base, with an occasional wild value
  function automatic logic [CHAN_W-1:0] jitter(input logic [CHAN_W-1:0] base);
    int v;
    if ($urandom_range(0, 9) == 0) return CHAN_W'($urandom);
    v = int'(base) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CHAN_W'(v);
  endfunction

  function automatic logic [RANGE_W-1:0] random_dim();
    case ($urandom_range(0, 11))
      0: return RANGE_W'(0);
      1: return RANGE_W'(1);
      2: return RANGE_W'(MAX_DIM);
      3: return RANGE_W'($urandom_range(MAX_DIM + 1, 8191));
      default: return RANGE_W'($urandom_range(16, MAX_DIM));
    endcase
  endfunction

  // Send one pixel beat; start stays high for back-to-back beats
  task automatic send_pixel(input wmhsm_in_t px);
    cfg_valid <= 1'b0;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    start   <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (busy);
    accumulate_pixel(px);
  endtask

  // Write one register; valid is lowered by whatever comes next
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RANGE_W-1:0] wdata);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= wdata;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLE: en_q     = wdata[0];
      CFG_RADIUS: radius_q = wdata[RAD_W-1:0];
      CFG_COLS:   cols_q   = wdata[DIM_W-1:0];
      CFG_ROWS:   rows_q   = wdata[DIM_W-1:0];
      CFG_RANGE_0, CFG_RANGE_1, CFG_RANGE_2, CFG_RANGE_3: range_q[idx[RANGE_SEL_W-1:0]] = wdata;
      default: ;
    endcase
  endtask

  // Hold the inputs quiet until every verdict is back, then let the pipe settle
  task automatic drain_results();
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    burst_left = 0;
    while (skin_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic got, input logic want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s at %0t: expected %b, got %b", what, $time, want, got);
  endtask

  task automatic test_default_frames();
    // in-window pixels whose mean sits in the first reset range
    send_pixel(pix(320, 240, 320, 240, 10, 50, 100, 1'b0));
    send_pixel(pix(0, 0, 310, 230, 12, 60, 90, 1'b0));
    send_pixel(pix(4095, 4095, 330, 250, 14, 40, 120, 1'b1));
    // a frame of one pixel, all channels at zero
    send_pixel(pix(0, 0, 0, 0, 0, 0, 0, 1'b1));
    // centre past the frame edge, all channels saturated
    send_pixel(pix(4095, 4095, 4095, 4095, 255, 255, 255, 1'b1));
    // nothing lands in the window
    send_pixel(pix(100, 100, 0, 0, 10, 50, 100, 1'b0));
    send_pixel(pix(100, 100, 4095, 0, 10, 50, 100, 1'b1));
    drain_results();
  endtask

  task automatic test_register_extremes();
    // filter off: an in-range frame still reads as not skin
    write_reg(CFG_ENABLE, RANGE_W'(0));
    send_pixel(pix(320, 240, 320, 240, 10, 50, 100, 1'b1));
    drain_results();
    write_reg(CFG_ENABLE, RANGE_W'(1));
    // zero radius collapses the window to a point
    write_reg(CFG_RADIUS, RANGE_W'(0));
    send_pixel(pix(320, 240, 320, 240, 10, 50, 100, 1'b1));
    drain_results();
    // widest window, largest frame, centre in the far corner
    write_reg(CFG_RADIUS, RANGE_W'(MAX_RADIUS));
    write_reg(CFG_COLS, RANGE_W'(MAX_DIM));
    write_reg(CFG_ROWS, RANGE_W'(MAX_DIM));
    send_pixel(pix(4095, 4095, 3900, 3900, 10, 50, 100, 1'b0));
    send_pixel(pix(0, 0, 3840, 4095, 20, 60, 110, 1'b1));
    drain_results();
    // frame of zero size
    write_reg(CFG_COLS, RANGE_W'(0));
    write_reg(CFG_ROWS, RANGE_W'(0));
    send_pixel(pix(0, 0, 0, 0, 10, 50, 100, 1'b1));
    drain_results();
    // oversize width clamps; a single row leaves no window height
    write_reg(CFG_COLS, RANGE_W'(8191));
    write_reg(CFG_ROWS, RANGE_W'(1));
    send_pixel(pix(5, 0, 5, 0, 10, 50, 100, 1'b1));
    drain_results();
    // 2x2 frame with radius one
    write_reg(CFG_RADIUS, RANGE_W'(1));
    write_reg(CFG_COLS, RANGE_W'(2));
    write_reg(CFG_ROWS, RANGE_W'(2));
    send_pixel(pix(1, 1, 0, 0, 10, 50, 100, 1'b0));
    send_pixel(pix(1, 1, 1, 1, 12, 52, 102, 1'b1));
    drain_results();
    // range 0 switched off, range 1 inverted, range 2 pinned at black, range 3 at white
    write_reg(CFG_RANGE_0, {1'b0, 48'h00_14_50_19_96_FF});
    write_reg(CFG_RANGE_1, {1'b1, 48'hFF_FF_FF_00_00_00});
    write_reg(CFG_RANGE_2, {1'b1, 48'h0});
    write_reg(CFG_RANGE_3, '1);
    write_reg(CFG_UNMAPPED, '1);
    send_pixel(pix(1, 1, 1, 1, 255, 255, 255, 1'b1));
    send_pixel(pix(0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_pixel(pix(0, 0, 1, 0, 10, 50, 100, 1'b1));
    drain_results();
    // back to the reset settings
    write_reg(CFG_ENABLE, RANGE_W'(RST_ENABLE));
    write_reg(CFG_RADIUS, RANGE_W'(RST_RADIUS));
    write_reg(CFG_COLS, RANGE_W'(RST_COLS));
    write_reg(CFG_ROWS, RANGE_W'(RST_ROWS));
    for (int k = 0; k < NUM_RANGES; k++) write_reg(CFG_IDX_W'(CFG_RANGE_0 + k), RST_RANGE[k]);
    drain_results();
  endtask

  task automatic shuffle_config();
    logic [RANGE_W-1:0] word;
    int lo, hi;
    if ($urandom_range(0, 2) == 0) write_reg(CFG_ENABLE, RANGE_W'($urandom_range(0, 5) != 0));
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 7))
        0: write_reg(CFG_RADIUS, RANGE_W'(0));
        1: write_reg(CFG_RADIUS, RANGE_W'(MAX_RADIUS));
        default: write_reg(CFG_RADIUS, RANGE_W'($urandom_range(1, 30)));
      endcase
    end
    if ($urandom_range(0, 2) == 0) write_reg(CFG_COLS, random_dim());
    if ($urandom_range(0, 2) == 0) write_reg(CFG_ROWS, random_dim());
    for (int k = 0; k < NUM_RANGES; k++) begin
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 5) == 0) begin
          word = RANGE_W'({$urandom, $urandom});
        end else begin
          // mostly valid, ordered bounds
          word     = '0;
          word[48] = ($urandom_range(0, 7) != 0);
          for (int c = 0; c < 3; c++) begin
            lo = $urandom_range(0, 200);
            hi = lo + $urandom_range(10, 90);
            if (hi > 255) hi = 255;
            word[47-8*c -: 8] = CHAN_W'(lo);
            word[23-8*c -: 8] = CHAN_W'(hi);
          end
        end
        write_reg(CFG_IDX_W'(CFG_RANGE_0 + k), word);
      end
    end
  endtask

  task automatic test_random_frames();
    int sent, frame_len, cx, cy, r, cols_eff, rows_eff;
    logic [RANGE_W-1:0] pick;
    logic [CHAN_W-1:0]  hb, sb, vb;
    wmhsm_in_t          px;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      // reprogram between frames now and then
      if ($urandom_range(0, 4) == 0) begin
        drain_results();
        shuffle_config();
      end
      gaps_on  = ($urandom_range(0, 5) != 0);
      cols_eff = int'(cols_q);
      rows_eff = int'(rows_q);
      if (cols_eff == 0 || cols_eff > MAX_DIM) cols_eff = MAX_DIM;
      if (rows_eff == 0 || rows_eff > MAX_DIM) rows_eff = MAX_DIM;
      if ($urandom_range(0, 7) == 0) begin
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
      end else begin
        cx = $urandom_range(0, cols_eff - 1);
        cy = $urandom_range(0, rows_eff - 1);
      end
      r = int'(radius_q);
      // aim the frame colour at one of the ranges, sometimes anywhere
      pick = range_q[RANGE_SEL_W'($urandom_range(0, NUM_RANGES - 1))];
      if ($urandom_range(0, 4) == 0) begin
        hb = CHAN_W'($urandom);
        sb = CHAN_W'($urandom);
        vb = CHAN_W'($urandom);
      end else begin
        hb = CHAN_W'($urandom_range(pick[47:40], pick[23:16]));
        sb = CHAN_W'($urandom_range(pick[39:32], pick[15:8]));
        vb = CHAN_W'($urandom_range(pick[31:24], pick[7:0]));
      end
      frame_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 16);
      for (int n = 1; n <= frame_len; n++) begin
        px.centre_x = (n == 1) ? COORD_W'(cx) : COORD_W'($urandom);
        px.centre_y = (n == 1) ? COORD_W'(cy) : COORD_W'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          px.pixel_x = COORD_W'($urandom);
          px.pixel_y = COORD_W'($urandom);
        end else begin
          px.pixel_x = COORD_W'(cx + $urandom_range(0, 2 * r + 4) - (r + 2));
          px.pixel_y = COORD_W'(cy + $urandom_range(0, 2 * r + 4) - (r + 2));
        end
        px.hue        = jitter(hb);
        px.saturation = jitter(sb);
        px.brightness = jitter(vb);
        px.frame_last = (n == frame_len);
        send_pixel(px);
        sent++;
      end
    end
    drain_results();
  endtask

  // Compare each result beat with the oldest pending verdict
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (skin_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result beat with nothing pending at %0t: is_skin %b score_code %b",
                   $time, out_data.is_skin, out_data.score_code);
      end else begin
        due_verdict = skin_verdicts.pop_front();
        if (out_data.is_skin !== due_verdict.is_skin)
          flag_mismatch("is_skin", out_data.is_skin, due_verdict.is_skin);
        if (out_data.score_code !== due_verdict.score_code)
          flag_mismatch("score_code", out_data.score_code, due_verdict.score_code);
      end
    end
  end

  // Abort when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    en_q       = RST_ENABLE;
    radius_q   = RST_RADIUS;
    cols_q     = RST_COLS;
    rows_q     = RST_ROWS;
    for (int k = 0; k < NUM_RANGES; k++) range_q[k] = RST_RANGE[k];
    hue_acc    = '0;
    sat_acc    = '0;
    val_acc    = '0;
    px_count   = '0;
    centre_col = '0;
    centre_row = '0;
    frame_open = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_default_frames();
    test_register_extremes();
    test_random_frames();
    drain_results();

    if (mismatches == 0 && skin_verdicts.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
